// ----- src/jdcal_pkg.sv -----
// ============================================================================
// jdcal_pkg
// Shared constants and small tables for the Julian Day to calendar date
// converter.
// ============================================================================
package jdcal_pkg;

    // Fixed output widths
    localparam int YEAR_W    = 16;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 21;
    localparam int HOUR_FRAC = 16;

    // Days past the start of the March-based year, plus 122, stay below 512
    localparam int BD_W = 9;
    // Month index from the 30.6001-day table, 0 to 15
    localparam int E_W  = 4;

    // Calendar constants
    localparam int GREG_START  = 2299161;  // first day number of the Gregorian calendar
    localparam int ALPHA_BIAS  = 7468865;  // 4 * 1867216.25
    localparam int GREG_CYCLE  = 146097;   // days in 400 Gregorian years
    localparam int JUL_CYCLE   = 1461;     // days in 4 Julian years
    localparam int B_OFFSET    = 1524;
    localparam int C_BIAS      = 489;      // floor(4 * 122.1) + 1
    localparam int YEAR_LATE   = 4716;     // for March to December
    localparam int YEAR_EARLY  = 4715;     // for January and February
    localparam int MONTH_WRAP  = 14;

    // floor(30.6001 * e): day offset where month index e begins
    function automatic logic [BD_W-1:0] month_start(input logic [E_W-1:0] e);
        logic [BD_W-1:0] res;
        case (e)
            4'd0:    res = BD_W'(0);
            4'd1:    res = BD_W'(30);
            4'd2:    res = BD_W'(61);
            4'd3:    res = BD_W'(91);
            4'd4:    res = BD_W'(122);
            4'd5:    res = BD_W'(153);
            4'd6:    res = BD_W'(183);
            4'd7:    res = BD_W'(214);
            4'd8:    res = BD_W'(244);
            4'd9:    res = BD_W'(275);
            4'd10:   res = BD_W'(306);
            4'd11:   res = BD_W'(336);
            4'd12:   res = BD_W'(367);
            4'd13:   res = BD_W'(397);
            4'd14:   res = BD_W'(428);
            default: res = BD_W'(459);
        endcase
        return res;
    endfunction

    // floor(bd * 10000 / 306001): count the month starts that bd passes.
    // 30.6001 * k is never an integer here, so bd reaches month k exactly
    // when it exceeds floor(30.6001 * k).
    function automatic logic [E_W-1:0] month_index(input logic [BD_W-1:0] bd);
        logic [E_W-1:0] res;
        res = '0;
        for (int k = 1; k < (1 << E_W); k++) begin
            if (bd > month_start(E_W'(k))) begin
                res = E_W'(k);
            end
        end
        return res;
    endfunction

endpackage

// ----- src/julian_day_to_calendar_date.sv -----
// ============================================================================
// julian_day_to_calendar_date
// Converts a fixed-point Julian Day into year, month, day and hour of day
// through a twelve-stage pipeline of constant multiplies and corrections.
// ============================================================================
// Usage: one item can enter every clock cycle when nothing stalls, and its
// date passes through every stage of the pipeline, which holds one multiply
// or one add-and-compare per stage. Each stage carries its own valid bit and
// advances whenever the stage after it is empty or moving, so a stall on the
// output fills empty stages first and input is still taken until every stage
// holds an item. The two divisions by the 400-year and 4-year cycles are
// reciprocal multiplies followed by a one-step correction. Years outside 16
// bits wrap; the hour keeps 16 fraction bits.
module julian_day_to_calendar_date
    import jdcal_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    parameter int DAY_BITS      = 23
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             jd_valid,
    output logic                             jd_stall,
    input  logic [DAY_BITS+FRACTION_BITS-1:0] jd_fixed,
    output logic                             cal_valid,
    input  logic                             cal_stall,
    output logic signed [YEAR_W-1:0]         cal_year,
    output logic [MONTH_W-1:0]               cal_month,
    output logic [DAY_W-1:0]                 cal_day,
    output logic [HOUR_W-1:0]                hour_fixed
);

    localparam int NS    = 12;                      // pipeline stages
    localparam int JW    = DAY_BITS + FRACTION_BITS;
    localparam int SUM_W = JW + 1;
    localparam int ZW    = DAY_BITS + 1;            // whole day number
    localparam int X1W   = ZW + 2;                  // 4z - bias
    localparam int AL_W  = X1W - 17;                // 146097 > 2^17
    localparam int BW    = ZW + 1;                  // a and b
    localparam int X2W   = BW + 2;                  // 4b - bias
    localparam int CW    = X2W - 10;                // 1461 > 2^10
    localparam int P1W   = X1W + AL_W;
    localparam int P2W   = X2W + CW;
    localparam int DPW   = CW + 11;
    localparam int HPW   = FRACTION_BITS + 5;       // fraction times 24

    localparam longint unsigned M1_FULL = (longint'(1) << X1W) / GREG_CYCLE;
    localparam longint unsigned M2_FULL = (longint'(1) << X2W) / JUL_CYCLE;
    localparam logic [AL_W-1:0] M1 = AL_W'(M1_FULL);
    localparam logic [CW-1:0]   M2 = CW'(M2_FULL);

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] stage_en;

    // Advance a stage when it is empty or the next one advances
    always_comb
    begin
        stage_en[NS-1] = !valid_reg[NS-1] || !cal_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_comb
    begin
        valid_next    = valid_reg;
        if (stage_en[0])
        begin
            valid_next[0] = jd_valid;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (stage_en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign jd_stall  = !stage_en[0];
    assign cal_valid = valid_reg[NS-1];

    // ------------------------------------------------------------------
    // Stage 1: add half a day, split day and fraction, scale the hour
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]  sum_half;
    logic [ZW-1:0]     z1_next;
    logic [FRACTION_BITS-1:0] frac1;
    logic              greg1_next;
    logic [X1W-1:0]    x1_1_next;
    logic [HPW-1:0]    hour_prod;
    logic [HOUR_W-1:0] hour1_next;

    assign sum_half   = {1'b0, jd_fixed} + (SUM_W'(1) << (FRACTION_BITS - 1));
    assign z1_next    = sum_half[SUM_W-1:FRACTION_BITS];
    assign frac1      = sum_half[FRACTION_BITS-1:0];
    assign greg1_next = (z1_next >= ZW'(GREG_START));
    assign x1_1_next  = {z1_next, 2'b00} - X1W'(ALPHA_BIAS);
    assign hour_prod  = (HPW'(frac1) << 4) + (HPW'(frac1) << 3);

    generate
        if (FRACTION_BITS >= HOUR_FRAC)
        begin : g_hour_trunc
            assign hour1_next = hour_prod[FRACTION_BITS-HOUR_FRAC +: HOUR_W];
        end
        else
        begin : g_hour_pad
            assign hour1_next = {hour_prod, (HOUR_FRAC - FRACTION_BITS)'(0)};
        end
    endgenerate

    logic [ZW-1:0]     z1_reg;
    logic              greg1_reg;
    logic [X1W-1:0]    x1_1_reg;
    logic [HOUR_W-1:0] hour1_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            z1_reg    <= z1_next;
            greg1_reg <= greg1_next;
            x1_1_reg  <= x1_1_next;
            hour1_reg <= hour1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: reciprocal multiply for the 400-year cycle count
    // ------------------------------------------------------------------
    logic [P1W-1:0]    p1_next;
    logic [P1W-1:0]    p1_reg;
    logic [ZW-1:0]     z2_reg;
    logic              greg2_reg;
    logic [X1W-1:0]    x1_2_reg;
    logic [HOUR_W-1:0] hour2_reg;

    assign p1_next = P1W'(x1_1_reg) * P1W'(M1);

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            p1_reg    <= p1_next;
            z2_reg    <= z1_reg;
            greg2_reg <= greg1_reg;
            x1_2_reg  <= x1_1_reg;
            hour2_reg <= hour1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: multiply the estimate back by the cycle length
    // ------------------------------------------------------------------
    logic [AL_W-1:0]   alpha0_next;
    logic [X1W-1:0]    prod1_next;
    logic [AL_W-1:0]   alpha0_reg;
    logic [X1W-1:0]    prod1_reg;
    logic [X1W-1:0]    x1_3_reg;
    logic [ZW-1:0]     z3_reg;
    logic              greg3_reg;
    logic [HOUR_W-1:0] hour3_reg;

    assign alpha0_next = p1_reg[X1W +: AL_W];
    assign prod1_next  = X1W'(alpha0_next) * X1W'(GREG_CYCLE);

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            alpha0_reg <= alpha0_next;
            prod1_reg  <= prod1_next;
            x1_3_reg   <= x1_2_reg;
            z3_reg     <= z2_reg;
            greg3_reg  <= greg2_reg;
            hour3_reg  <= hour2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: correct the estimate by one when the remainder overflows
    // ------------------------------------------------------------------
    logic [X1W-1:0]    rem1;
    logic [AL_W-1:0]   alpha_next;
    logic [AL_W-1:0]   alpha_reg;
    logic [ZW-1:0]     z4_reg;
    logic              greg4_reg;
    logic [HOUR_W-1:0] hour4_reg;

    assign rem1       = x1_3_reg - prod1_reg;
    assign alpha_next = alpha0_reg + AL_W'(rem1 >= X1W'(GREG_CYCLE));

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            alpha_reg <= alpha_next;
            z4_reg    <= z3_reg;
            greg4_reg <= greg3_reg;
            hour4_reg <= hour3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: apply the Gregorian correction and the day offset
    // ------------------------------------------------------------------
    logic [BW-1:0]     adj5;
    logic [BW-1:0]     b5_next;
    logic [BW-1:0]     b5_reg;
    logic [HOUR_W-1:0] hour5_reg;

    assign adj5    = greg4_reg ? (BW'(alpha_reg) + BW'(1) - BW'(alpha_reg >> 2)) : '0;
    assign b5_next = BW'(z4_reg) + adj5 + BW'(B_OFFSET);

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            b5_reg    <= b5_next;
            hour5_reg <= hour4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: reciprocal multiply for the year count
    // ------------------------------------------------------------------
    logic [X2W-1:0]    x2_6_next;
    logic [P2W-1:0]    p2_next;
    logic [P2W-1:0]    p2_reg;
    logic [X2W-1:0]    x2_6_reg;
    logic [BW-1:0]     b6_reg;
    logic [HOUR_W-1:0] hour6_reg;

    assign x2_6_next = {b5_reg, 2'b00} - X2W'(C_BIAS);
    assign p2_next   = P2W'(x2_6_next) * P2W'(M2);

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            p2_reg    <= p2_next;
            x2_6_reg  <= x2_6_next;
            b6_reg    <= b5_reg;
            hour6_reg <= hour5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: multiply the year estimate back by the 4-year cycle
    // ------------------------------------------------------------------
    logic [CW-1:0]     c0_next;
    logic [X2W-1:0]    prod2_next;
    logic [CW-1:0]     c0_reg;
    logic [X2W-1:0]    prod2_reg;
    logic [X2W-1:0]    x2_7_reg;
    logic [BW-1:0]     b7_reg;
    logic [HOUR_W-1:0] hour7_reg;

    assign c0_next    = p2_reg[X2W +: CW];
    assign prod2_next = X2W'(c0_next) * X2W'(JUL_CYCLE);

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            c0_reg    <= c0_next;
            prod2_reg <= prod2_next;
            x2_7_reg  <= x2_6_reg;
            b7_reg    <= b6_reg;
            hour7_reg <= hour6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: correct the year estimate
    // ------------------------------------------------------------------
    logic [X2W-1:0]    rem2;
    logic [CW-1:0]     c8_next;
    logic [CW-1:0]     c8_reg;
    logic [BW-1:0]     b8_reg;
    logic [HOUR_W-1:0] hour8_reg;

    assign rem2    = x2_7_reg - prod2_reg;
    assign c8_next = c0_reg + CW'(rem2 >= X2W'(JUL_CYCLE));

    always_ff @(posedge clk)
    begin
        if (stage_en[7])
        begin
            c8_reg    <= c8_next;
            b8_reg    <= b7_reg;
            hour8_reg <= hour7_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: days up to the start of the year, 1461 c / 4
    // ------------------------------------------------------------------
    logic [DPW-1:0]    dprod;
    logic [BW-1:0]     d9_next;
    logic [BW-1:0]     d9_reg;
    logic [CW-1:0]     c9_reg;
    logic [BW-1:0]     b9_reg;
    logic [HOUR_W-1:0] hour9_reg;

    assign dprod   = DPW'(c8_reg) * DPW'(JUL_CYCLE);
    assign d9_next = dprod[2 +: BW];

    always_ff @(posedge clk)
    begin
        if (stage_en[8])
        begin
            d9_reg    <= d9_next;
            c9_reg    <= c8_reg;
            b9_reg    <= b8_reg;
            hour9_reg <= hour8_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: day offset inside the March-based year
    // ------------------------------------------------------------------
    logic [BW-1:0]     bdiff;
    logic [BD_W-1:0]   bd10_next;
    logic [BD_W-1:0]   bd10_reg;
    logic [CW-1:0]     c10_reg;
    logic [HOUR_W-1:0] hour10_reg;

    assign bdiff     = b9_reg - d9_reg;
    assign bd10_next = bdiff[BD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (stage_en[9])
        begin
            bd10_reg   <= bd10_next;
            c10_reg    <= c9_reg;
            hour10_reg <= hour9_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: month index from the month start table
    // ------------------------------------------------------------------
    logic [E_W-1:0]    e11_next;
    logic [E_W-1:0]    e11_reg;
    logic [BD_W-1:0]   bd11_reg;
    logic [CW-1:0]     c11_reg;
    logic [HOUR_W-1:0] hour11_reg;

    assign e11_next = month_index(bd10_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[10])
        begin
            e11_reg    <= e11_next;
            bd11_reg   <= bd10_reg;
            c11_reg    <= c10_reg;
            hour11_reg <= hour10_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 12: day, month and year into the output register
    // ------------------------------------------------------------------
    logic [BD_W-1:0]     day_full;
    logic [MONTH_W-1:0]  month_next;
    logic [DAY_W-1:0]    day_next;
    logic [YEAR_W-1:0]   year_next;
    logic [YEAR_W-1:0]   year_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [DAY_W-1:0]    day_reg;
    logic [HOUR_W-1:0]   hour_reg;

    assign day_full   = bd11_reg - month_start(e11_reg);
    assign day_next   = day_full[DAY_W-1:0];
    assign month_next = (e11_reg < E_W'(MONTH_WRAP)) ? MONTH_W'(e11_reg - E_W'(1))
                                                     : MONTH_W'(e11_reg - E_W'(13));
    assign year_next  = (month_next > MONTH_W'(2))
                        ? (c11_reg[YEAR_W-1:0] - YEAR_W'(YEAR_LATE))
                        : (c11_reg[YEAR_W-1:0] - YEAR_W'(YEAR_EARLY));

    always_ff @(posedge clk)
    begin
        if (stage_en[11])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            hour_reg  <= hour11_reg;
        end
    end

    assign cal_year   = year_reg;
    assign cal_month  = month_reg;
    assign cal_day    = day_reg;
    assign hour_fixed = hour_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_valid |-> (cal_month >= MONTH_W'(1)) && (cal_month <= MONTH_W'(12)))
        else $error("month out of range");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_valid |-> (cal_day >= DAY_W'(1)) && (cal_day <= DAY_W'(31)))
        else $error("day out of range");

    a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_valid |-> (hour_fixed < HOUR_W'(24 << HOUR_FRAC)))
        else $error("hour not below 24");

    a_open_entry: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> !jd_stall)
        else $error("input stalled with empty first stage");

endmodule

// ----- bench/julian_day_to_calendar_date_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// julian_day_to_calendar_date_tb
// Streams fixed-point Julian Days into the date converter and checks every
// year, month, day and hour against a typed-in date or an in-bench calculation,
// with random gaps on the input and random stalls on the output.
// ============================================================================
module julian_day_to_calendar_date_tb;
    import jdcal_pkg::*;

    localparam int FRACTION_BITS = 16;
    localparam int DAY_BITS      = 23;
    localparam int JD_W          = DAY_BITS + FRACTION_BITS;
    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int DRAIN_CYCLES  = 40;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int ROW_COUNT     = 18;

    localparam logic [63:0] ONE_DAY  = 64'd1 << FRACTION_BITS;
    localparam logic [63:0] HALF_DAY = 64'd1 << (FRACTION_BITS - 1);

    // Calendar arithmetic constants, scaled to exact integers
    localparam logic [63:0] FIRST_GREGORIAN = 64'd2299161;
    localparam logic [63:0] CENTURY_BIAS    = 64'd7468865;
    localparam logic [63:0] DAYS_400_YEARS  = 64'd146097;
    localparam logic [63:0] DAY_SHIFT       = 64'd1524;
    localparam logic [63:0] YEAR_BIAS_X20   = 64'd2442;
    localparam logic [63:0] DAYS_20_YEARS   = 64'd7305;
    localparam logic [63:0] DAYS_4_YEARS    = 64'd1461;
    localparam logic [63:0] MONTH_LEN_X1E4  = 64'd306001;
    localparam logic [63:0] SCALE_1E4       = 64'd10000;
    localparam longint      EPOCH_LATE      = 4716;
    localparam longint      EPOCH_EARLY     = 4715;

    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [HOUR_W-1:0]        hour;
    } cal_date_t;

    typedef struct packed {
        logic [JD_W-1:0] jd;
        bit              typed;
        cal_date_t       want;
    } date_row_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              jd_valid  = 1'b0;
    logic              jd_stall;
    logic [JD_W-1:0]   jd_fixed  = '0;
    logic              cal_valid;
    logic              cal_stall = 1'b0;
    logic signed [YEAR_W-1:0] cal_year;
    logic [MONTH_W-1:0] cal_month;
    logic [DAY_W-1:0]  cal_day;
    logic [HOUR_W-1:0] hour_fixed;

    cal_date_t  pending_dates[$];
    date_row_t  directed_rows [ROW_COUNT];
    int         mismatches   = 0;
    int         idle_cycles  = 0;
    int         stall_run    = 0;
    bit         steady       = 1'b0;

    julian_day_to_calendar_date #(
        .FRACTION_BITS(FRACTION_BITS),
        .DAY_BITS     (DAY_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .jd_valid  (jd_valid),
        .jd_stall  (jd_stall),
        .jd_fixed  (jd_fixed),
        .cal_valid (cal_valid),
        .cal_stall (cal_stall),
        .cal_year  (cal_year),
        .cal_month (cal_month),
        .cal_day   (cal_day),
        .hour_fixed(hour_fixed)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Convert one Julian Day into the calendar date it names
    function automatic cal_date_t predict_date(input logic [JD_W-1:0] jd);
        logic [63:0] shifted_jd, whole, frac, alpha, greg_day, base, years_x4;
        logic [63:0] year_start, month_idx, month_num, hours, day_val;
        longint      full_year;
        cal_date_t   res;
        shifted_jd = 64'(jd) + HALF_DAY;
        whole      = shifted_jd >> FRACTION_BITS;
        frac       = shifted_jd & (ONE_DAY - 1);

        // apply the century correction from the Gregorian switch on
        if (whole < FIRST_GREGORIAN)
        begin
            greg_day = whole;
        end
        else
        begin
            alpha    = (4 * whole - CENTURY_BIAS) / DAYS_400_YEARS;
            greg_day = whole + 1 + alpha - alpha / 4;
        end
        base       = greg_day + DAY_SHIFT;
        years_x4   = (20 * base - YEAR_BIAS_X20) / DAYS_20_YEARS;
        year_start = (DAYS_4_YEARS * years_x4) / 4;
        month_idx  = ((base - year_start) * SCALE_1E4) / MONTH_LEN_X1E4;
        month_num  = (month_idx < 14) ? month_idx - 1 : month_idx - 13;
        full_year  = longint'(years_x4) - ((month_num > 2) ? EPOCH_LATE : EPOCH_EARLY);
        day_val    = base - year_start - (MONTH_LEN_X1E4 * month_idx) / SCALE_1E4;

        hours = frac * 24;
        if (FRACTION_BITS >= HOUR_FRAC)
        begin
            hours = hours >> (FRACTION_BITS - HOUR_FRAC);
        end
        else
        begin
            hours = hours << (HOUR_FRAC - FRACTION_BITS);
        end

        res.year  = full_year[YEAR_W-1:0];
        res.month = month_num[MONTH_W-1:0];
        res.day   = day_val[DAY_W-1:0];
        res.hour  = hours[HOUR_W-1:0];
        return res;
    endfunction

    // Mostly short pauses, now and then a long one
    function automatic int pause_length();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(20, 80);
        end
        return $urandom_range(1, 4);
    endfunction

    // Pick a Julian Day, weighted toward the interesting parts of the range
    function automatic logic [JD_W-1:0] random_jd();
        logic [DAY_BITS-1:0]      day_num;
        logic [FRACTION_BITS-1:0] frac;
        logic [63:0]              wide;
        wide    = {$urandom(), $urandom()};
        day_num = wide[JD_W-1:FRACTION_BITS];
        frac    = wide[FRACTION_BITS-1:0];
        case ($urandom_range(0, 8))
            4: day_num = DAY_BITS'(FIRST_GREGORIAN - 400 + $urandom_range(0, 800));
            5: day_num = DAY_BITS'($urandom_range(0, 3000));
            6: day_num = {DAY_BITS{1'b1}} - DAY_BITS'($urandom_range(0, 3000));
            7: day_num = DAY_BITS'($urandom_range(2400000, 2500000));
            8:
            begin
                case ($urandom_range(0, 4))
                    0: frac = '0;
                    1: frac = FRACTION_BITS'(HALF_DAY - 1);
                    2: frac = FRACTION_BITS'(HALF_DAY);
                    3: frac = FRACTION_BITS'(HALF_DAY + 1);
                    default: frac = '1;
                endcase
            end
            default: ;
        endcase
        return {day_num, frac};
    endfunction

    // Offer one item after an optional gap and hold it until taken
    task automatic offer_jd(input logic [JD_W-1:0] value, input bit typed,
                            input cal_date_t want);
        int gap;
        gap = (steady || $urandom_range(0, 99) < 55) ? 0 : pause_length();
        if (gap != 0)
        begin
            jd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        jd_valid <= 1'b1;
        jd_fixed <= value;
        do @(posedge clk); while (jd_stall !== 1'b0);
        pending_dates.push_back(typed ? want : predict_date(value));
    endtask

    // Drop valid and hold off until every pending date has come back
    task automatic drain_pending();
        jd_valid <= 1'b0;
        @(posedge clk);
        while (pending_dates.size() != 0) @(posedge clk);
    endtask

    // Stall the output in random runs, none while steady
    always @(posedge clk)
    begin
        if (!rst_n || steady)
        begin
            cal_stall <= 1'b0;
            stall_run <= 0;
        end
        else if (stall_run > 0)
        begin
            stall_run <= stall_run - 1;
        end
        else if (cal_stall)
        begin
            cal_stall <= 1'b0;
            stall_run <= $urandom_range(0, 11);
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            cal_stall <= 1'b1;
            stall_run <= pause_length() - 1;
        end
    end

    // Compare each taken result with the oldest pending date
    always @(posedge clk)
    begin : check_result
        cal_date_t want;
        if (rst_n && cal_valid === 1'b1 && cal_stall == 1'b0)
        begin
            if (pending_dates.size() == 0)
            begin
                $error("unexpected date %0d-%0d-%0d, nothing pending",
                       cal_year, cal_month, cal_day);
                mismatches++;
            end
            else
            begin
                want = pending_dates.pop_front();
                if (cal_year !== want.year)
                begin
                    $error("cal_year: expected %0d, got %0d", want.year, cal_year);
                    mismatches++;
                end
                if (cal_month !== want.month)
                begin
                    $error("cal_month: expected %0d, got %0d", want.month, cal_month);
                    mismatches++;
                end
                if (cal_day !== want.day)
                begin
                    $error("cal_day: expected %0d, got %0d", want.day, cal_day);
                    mismatches++;
                end
                if (hour_fixed !== want.hour)
                begin
                    $error("hour_fixed: expected %0d, got %0d", want.hour, hour_fixed);
                    mismatches++;
                end
            end
        end
    end

    // Count cycles in which neither side moves an item
    always @(posedge clk)
    begin
        if ((jd_valid && jd_stall === 1'b0) || (cal_valid === 1'b1 && !cal_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_MAX) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [JD_W-1:0] jd_val;
        // Epoch, calendar switch, extremes, leap days and fraction edges
        directed_rows = '{
            '{JD_W'(0),                          1'b1, '{-16'sd4712, 4'd1, 5'd1, 21'd786432}},
            '{{JD_W{1'b1}},                      1'b0, '0},
            '{JD_W'(1),                          1'b0, '0},
            '{JD_W'(HALF_DAY - 1),               1'b0, '0},
            '{JD_W'(HALF_DAY),                   1'b0, '0},
            '{JD_W'(2451545 * ONE_DAY),          1'b1, '{16'sd2000, 4'd1, 5'd1, 21'd786432}},
            '{JD_W'(2299160 * ONE_DAY + HALF_DAY), 1'b1, '{16'sd1582, 4'd10, 5'd15, 21'd0}},
            '{JD_W'(2299159 * ONE_DAY + HALF_DAY), 1'b1, '{16'sd1582, 4'd10, 5'd4, 21'd0}},
            '{JD_W'(2299160 * ONE_DAY + HALF_DAY - 1), 1'b0, '0},
            '{JD_W'(2451603 * ONE_DAY + HALF_DAY), 1'b0, '0},
            '{JD_W'(2415079 * ONE_DAY + HALF_DAY), 1'b0, '0},
            '{JD_W'(2451543 * ONE_DAY + HALF_DAY), 1'b0, '0},
            '{JD_W'(1721117 * ONE_DAY + HALF_DAY), 1'b0, '0},
            '{JD_W'(2268932 * ONE_DAY + HALF_DAY), 1'b0, '0},
            '{JD_W'(8388607 * ONE_DAY + HALF_DAY - 1), 1'b0, '0},
            '{JD_W'(8388607 * ONE_DAY + HALF_DAY), 1'b0, '0},
            '{39'h55_5555_5555,                  1'b0, '0},
            '{39'h2A_AAAA_AAAA,                  1'b0, '0}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_jd(directed_rows[i].jd, directed_rows[i].typed, directed_rows[i].want);
        end
        drain_pending();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // run a stretch with no gaps and no stalls, then pause once
            if (i == 500) steady <= 1'b1;
            if (i == 700) steady <= 1'b0;
            if (i == 1000) drain_pending();
            jd_val = random_jd();
            offer_jd(jd_val, 1'b0, '0);
        end
        jd_valid <= 1'b0;

        while (pending_dates.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
